[hw/rtl/promotable_max_priority_table_assert.svh]
// Assertion macros for the checker file.
`ifndef PROMOTABLE_MAX_PRIORITY_TABLE_ASSERT_SVH
`define PROMOTABLE_MAX_PRIORITY_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PMPT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pmpt assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PMPT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pmpt assertion failed");

`endif

[hw/rtl/pmpt_pkg.sv]
package pmpt_pkg;

    localparam int DATA_W        = 32;
    localparam int PRIO_W        = 16;
    localparam int ID_FIELD_W    = 8;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 2;
    localparam int DEPTH_DEFAULT = 256;

    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_PROMOTE  = 3'd1;
    localparam logic [OP_W-1:0] OP_GET_MAX  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_MAX  = 3'd3;
    localparam logic [OP_W-1:0] OP_IS_VALID = 3'd4;
    localparam logic [OP_W-1:0] OP_GET      = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_ID = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]       operation;
        logic [ID_FIELD_W-1:0] entry_id;
        logic [DATA_W-1:0]     data_in;
    } req_t;

    typedef struct packed {
        logic [ID_FIELD_W-1:0] new_id;
        logic [DATA_W-1:0]     data_out;
        logic [PRIO_W-1:0]     priority_out;
        logic                  valid_out;
        logic [STATUS_W-1:0]   status;
    } rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic lookup_rd;
        logic scan_start;
        logic scan_issue;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            nf_zero;
        logic            scan_last;
    } stat_t;

endpackage

[hw/rtl/pmpt_datapath.sv]
module pmpt_datapath #(
    parameter int DEPTH = pmpt_pkg::DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pmpt_pkg::req_t   req,
    input  pmpt_pkg::cmd_t   cmd,
    output pmpt_pkg::stat_t  stat,
    output pmpt_pkg::rsp_t   rsp
);

    localparam int ID_W  = $clog2(DEPTH);
    localparam int CNT_W = ID_W + 1;
    localparam int CMP_W = (CNT_W > pmpt_pkg::ID_FIELD_W) ? CNT_W : pmpt_pkg::ID_FIELD_W;

    typedef struct packed {
        logic                        live;
        logic [pmpt_pkg::PRIO_W-1:0] prio;
        logic [pmpt_pkg::DATA_W-1:0] data;
    } entry_t;

    entry_t mem [DEPTH];

    logic [pmpt_pkg::OP_W-1:0]       op_reg;
    logic [pmpt_pkg::ID_FIELD_W-1:0] id_reg;
    logic [pmpt_pkg::DATA_W-1:0]     din_reg;
    logic [CNT_W-1:0]                nf_reg;
    entry_t                          rd_reg;
    logic [ID_W-1:0]                 scan_addr_reg;
    logic [ID_W-1:0]                 scan_id_reg;
    logic                            scan_vld_reg;
    logic                            best_found_reg;
    logic [ID_W-1:0]                 best_id_reg;
    logic [pmpt_pkg::PRIO_W-1:0]     best_prio_reg;
    logic [pmpt_pkg::DATA_W-1:0]     best_data_reg;
    pmpt_pkg::rsp_t                  rsp_reg;
    pmpt_pkg::rsp_t                  rsp_next;

    logic                        full;
    logic                        id_ok;
    logic                        rd_en;
    logic [ID_W-1:0]             rd_addr;
    logic                        wr_en;
    logic [ID_W-1:0]             wr_addr;
    entry_t                      wr_data;
    logic [pmpt_pkg::PRIO_W-1:0] prio_inc;
    logic                        take_best;
    logic                        add_ok;

    assign full     = (nf_reg == CNT_W'(DEPTH));
    assign id_ok    = (CMP_W'(id_reg) < CMP_W'(nf_reg));
    assign rd_en    = cmd.lookup_rd | cmd.scan_issue;
    assign rd_addr  = cmd.scan_issue ? scan_addr_reg : ID_W'(id_reg);
    assign prio_inc = (&rd_reg.prio) ? rd_reg.prio : rd_reg.prio + pmpt_pkg::PRIO_W'(1);
    assign add_ok   = cmd.finish && (op_reg == pmpt_pkg::OP_ADD) && !full;

    // Scan runs in ascending id order, so >= hands ties to the higher id
    assign take_best = scan_vld_reg && rd_reg.live &&
                       (!best_found_reg || (rd_reg.prio >= best_prio_reg));

    assign stat.op        = op_reg;
    assign stat.nf_zero   = (nf_reg == '0);
    assign stat.scan_last = ((CNT_W'(scan_addr_reg) + CNT_W'(1)) == nf_reg);

    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = ID_W'(id_reg);
        wr_data  = '0;
        rsp_next = '0;
        rsp_next.status = pmpt_pkg::STATUS_OK;
        case (op_reg)
            pmpt_pkg::OP_ADD:
            begin
                if (full)
                begin
                    rsp_next.status = pmpt_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en           = cmd.finish;
                    wr_addr         = nf_reg[ID_W-1:0];
                    wr_data.live    = 1'b1;
                    wr_data.prio    = '0;
                    wr_data.data    = din_reg;
                    rsp_next.new_id = pmpt_pkg::ID_FIELD_W'(nf_reg);
                end
            end
            pmpt_pkg::OP_PROMOTE:
            begin
                if (!id_ok || !rd_reg.live)
                begin
                    rsp_next.status = pmpt_pkg::STATUS_BAD_ID;
                end
                else
                begin
                    wr_en                 = cmd.finish;
                    wr_data.live          = 1'b1;
                    wr_data.prio          = prio_inc;
                    wr_data.data          = rd_reg.data;
                    rsp_next.data_out     = rd_reg.data;
                    rsp_next.priority_out = prio_inc;
                    rsp_next.valid_out    = 1'b1;
                end
            end
            pmpt_pkg::OP_GET_MAX, pmpt_pkg::OP_POP_MAX:
            begin
                if (stat.nf_zero || !best_found_reg)
                begin
                    rsp_next.status = pmpt_pkg::STATUS_EMPTY;
                end
                else
                begin
                    rsp_next.data_out     = best_data_reg;
                    rsp_next.priority_out = best_prio_reg;
                    rsp_next.valid_out    = 1'b1;
                    // Retire the winner on pop_max
                    wr_en        = cmd.finish && (op_reg == pmpt_pkg::OP_POP_MAX);
                    wr_addr      = best_id_reg;
                    wr_data.live = 1'b0;
                    wr_data.prio = best_prio_reg;
                    wr_data.data = best_data_reg;
                end
            end
            pmpt_pkg::OP_IS_VALID:
            begin
                rsp_next.valid_out = id_ok && rd_reg.live;
            end
            pmpt_pkg::OP_GET:
            begin
                if (!id_ok || !rd_reg.live)
                begin
                    rsp_next.status = pmpt_pkg::STATUS_BAD_ID;
                end
                else
                begin
                    rsp_next.data_out     = rd_reg.data;
                    rsp_next.priority_out = rd_reg.prio;
                    rsp_next.valid_out    = 1'b1;
                end
            end
            default:
            begin
                rsp_next.status = pmpt_pkg::STATUS_OK;
            end
        endcase
    end

    // Entries at or above the fill count are never read as live, so the
    // table needs no clearing after reset.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nf_reg         <= '0;
            scan_addr_reg  <= '0;
            scan_vld_reg   <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            if (add_ok)
            begin
                nf_reg <= nf_reg + CNT_W'(1);
            end
            if (cmd.scan_start)
            begin
                scan_addr_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_addr_reg <= scan_addr_reg + ID_W'(1);
            end
            scan_vld_reg <= cmd.scan_issue;
            if (cmd.scan_start)
            begin
                best_found_reg <= 1'b0;
            end
            else if (take_best)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= req.operation;
            id_reg  <= req.entry_id;
            din_reg <= req.data_in;
        end
        if (cmd.scan_issue)
        begin
            scan_id_reg <= scan_addr_reg;
        end
        if (take_best)
        begin
            best_id_reg   <= scan_id_reg;
            best_prio_reg <= rd_reg.prio;
            best_data_reg <= rd_reg.data;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

[hw/rtl/pmpt_ctrl.sv]
module pmpt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    input  pmpt_pkg::stat_t stat,
    output pmpt_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOOKUP,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (stat.op)
                    pmpt_pkg::OP_PROMOTE, pmpt_pkg::OP_IS_VALID, pmpt_pkg::OP_GET:
                    begin
                        cmd.lookup_rd = 1'b1;
                        state_next    = ST_LOOKUP;
                    end
                    pmpt_pkg::OP_GET_MAX, pmpt_pkg::OP_POP_MAX:
                    begin
                        if (!stat.nf_zero)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end
                        else if (out_free)
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        // add and unused codes finish here
                        if (out_free)
                        begin
                            cmd.finish = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_LOOKUP, ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read is compared this cycle
                state_next = ST_FINISH;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/promotable_max_priority_table.sv]
// Channel   Valid       Stall       Payload            Direction
// request   req_valid   req_stall   req (req_t)        in
// result    rsp_valid   rsp_stall   rsp (rsp_t)        out
//
// add and unused codes: result registered from the dispatch state, no table read.
// promote, is_valid, get: one table read, then the result; no new item taken meanwhile.
// get_max and pop_max read the table one entry per cycle through its single read
// port, ids below next_free_id, then compare the last read and register the result.
// Reset is asynchronous and clears only the fill count and control state.
// A result waiting on rsp_stall holds; the next item is accepted meanwhile.
module promotable_max_priority_table #(
    parameter int DEPTH = pmpt_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  pmpt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pmpt_pkg::rsp_t rsp
);

    pmpt_pkg::cmd_t  cmd;
    pmpt_pkg::stat_t stat;

    pmpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    pmpt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

[hw/rtl/pmpt_checker.sv]
`include "promotable_max_priority_table_assert.svh"

module pmpt_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input pmpt_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input pmpt_pkg::rsp_t rsp
);

    // A stalled result holds
    `PMPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // An accepted item keeps the block busy for at least the next cycle
    `PMPT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

    // A new result only comes out of work that was in progress
    `PMPT_ASSERT_NOW(a_rsp_from_work, $rose(rsp_valid), $past(req_stall))

    // A result marked live always carries an ok status
    `PMPT_ASSERT_NOW(a_live_ok, rsp_valid && rsp.valid_out,
        rsp.status == pmpt_pkg::STATUS_OK)

endmodule

bind promotable_max_priority_table pmpt_checker u_pmpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
